/* sv/qmm_pkg.sv */
// qmm_pkg: shared widths, register indexes, reset values and constants
// for the quad motor mixer; used by quad_motor_mixer.sv
// depends on nothing
package qmm_pkg;

  // field widths
  localparam int THR_W   = 10;
  localparam int CMD_W   = 11;
  localparam int GAIN_W  = 12;
  localparam int TG_W    = 10;
  localparam int PWM_W   = 14;
  localparam int SPEED_W = 10;
  localparam int MOTORS  = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_GAIN    = 3'd0,
    REG_ROLL_GAIN     = 3'd1,
    REG_YAW_GAIN      = 3'd2,
    REG_THROTTLE_GAIN = 3'd3,
    REG_ROLL_REVERSE  = 3'd4,
    REG_PWM_MIN       = 3'd5,
    REG_PWM_MAX       = 3'd6
  } cfg_reg_t;

  // reset values
  localparam logic [GAIN_W-1:0] PITCH_GAIN_RST    = 12'd1000;
  localparam logic [GAIN_W-1:0] ROLL_GAIN_RST     = 12'd1000;
  localparam logic [GAIN_W-1:0] YAW_GAIN_RST      = 12'd1000;
  localparam logic [TG_W-1:0]   THROTTLE_GAIN_RST = 10'd1000;
  localparam logic [PWM_W-1:0]  PWM_MIN_RST       = 14'd817;
  localparam logic [PWM_W-1:0]  PWM_MAX_RST       = 14'd1640;

  // full-scale speed
  localparam logic [SPEED_W-1:0] SPEED_FULL = 10'd1000;

  // divide by 1000 as multiply by ceil(2^33/1000) then shift by 33;
  // exact for operands below about 21 million
  localparam int RECIP_SHIFT = 33;
  localparam int RECIP_W     = 24;
  localparam longint RECIP_VAL = ((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000;
  localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_VAL[RECIP_W-1:0];

  // quotient bits of the attitude divide; larger quotients saturate
  localparam int QBITS = 11;

endpackage

/* sv/quad_motor_mixer.sv */
// quad_motor_mixer: pipelined x-frame mixer, gain scaling, divide by gain sum,
// throttle base, clamp and pwm mapping
// depends on qmm_pkg
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | throttle, pitch, roll, yaw command
//  m_axis   | out | m_axis_tvalid/tready   | four speeds, four pwm counts
//  cfg      | in  | cfg_we (no wait)       | gains, roll reverse, pwm limits
//
// one item per cycle while the output is not stalled; the pipeline depth is set by
// the restoring divider, one quotient bit per stage, plus the multiply stages
// reset clears the valid bits and loads the register defaults
// a stall at the output freezes every stage at once; nothing is dropped
// configuration is read live by each stage, so it must be written only idle
module quad_motor_mixer (
  input  logic                            clk,
  input  logic                            rst,
  // throttle_cmd[9:0], pitch_cmd[20:10], roll_cmd[31:21], yaw_cmd[42:32], zero pad
  input  logic [47:0]                     s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // motor0..3_speed[39:0] 10 bits each, motor0..3_pwm[95:40] 14 bits each
  output logic [95:0]                     m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we,
  input  logic [qmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NSTG  = 19;              // total register stages
  localparam int DSTG  = qmm_pkg::QBITS + 1; // overflow check plus quotient steps
  localparam int D0    = 3;               // valid index of first divider stage
  localparam int S_CLP = D0 + DSTG;       // clamp stage
  localparam int S_SPN = S_CLP + 1;       // speed times span
  localparam int S_REC = S_SPN + 1;       // reciprocal multiply
  localparam int S_OUT = S_REC + 1;       // output register
  localparam int M     = qmm_pkg::MOTORS;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [qmm_pkg::GAIN_W-1:0] pitch_gain, roll_gain, yaw_gain;
  logic [qmm_pkg::TG_W-1:0]   throttle_gain;
  logic                       roll_reverse;
  logic [qmm_pkg::PWM_W-1:0]  pwm_min, pwm_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_gain    <= qmm_pkg::PITCH_GAIN_RST;
      roll_gain     <= qmm_pkg::ROLL_GAIN_RST;
      yaw_gain      <= qmm_pkg::YAW_GAIN_RST;
      throttle_gain <= qmm_pkg::THROTTLE_GAIN_RST;
      roll_reverse  <= 1'b0;
      pwm_min       <= qmm_pkg::PWM_MIN_RST;
      pwm_max       <= qmm_pkg::PWM_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qmm_pkg::REG_PITCH_GAIN:    pitch_gain    <= cfg_data[qmm_pkg::GAIN_W-1:0];
        qmm_pkg::REG_ROLL_GAIN:     roll_gain     <= cfg_data[qmm_pkg::GAIN_W-1:0];
        qmm_pkg::REG_YAW_GAIN:      yaw_gain      <= cfg_data[qmm_pkg::GAIN_W-1:0];
        qmm_pkg::REG_THROTTLE_GAIN: throttle_gain <= cfg_data[qmm_pkg::TG_W-1:0];
        qmm_pkg::REG_ROLL_REVERSE:  roll_reverse  <= cfg_data[0];
        qmm_pkg::REG_PWM_MIN:       pwm_min       <= cfg_data;
        qmm_pkg::REG_PWM_MAX:       pwm_max       <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived config values; the user keeps them static while items are in flight, the block does not enforce it
  logic [13:0] gsum;
  logic [24:0] gsum_x;
  logic        span_neg;
  logic [13:0] span_abs;

  assign gsum     = 14'(pitch_gain) + 14'(roll_gain) + 14'(yaw_gain);
  assign gsum_x   = {11'd0, gsum};
  assign span_neg = pwm_max < pwm_min;
  assign span_abs = span_neg ? (pwm_min - pwm_max) : (pwm_max - pwm_min);

  // ---------------------------------------------------------------------------
  // pipeline control: one shared enable, valid bits ride along
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic            en;

  assign en            = ~vld[S_OUT] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: gain products and throttle product
  // ---------------------------------------------------------------------------
  logic [qmm_pkg::THR_W-1:0]        in_thr;
  logic signed [qmm_pkg::CMD_W-1:0] in_pitch, in_roll, in_yaw;
  logic signed [23:0]               roll_prod;

  assign in_thr   = s_axis_tdata[9:0];
  assign in_pitch = s_axis_tdata[20:10];
  assign in_roll  = s_axis_tdata[31:21];
  assign in_yaw   = s_axis_tdata[42:32];
  assign roll_prod = in_roll * $signed({1'b0, roll_gain});

  logic signed [23:0] s1_p, s1_r, s1_y;
  logic [19:0]        s1_thr;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p   <= in_pitch * $signed({1'b0, pitch_gain});
      s1_y   <= in_yaw * $signed({1'b0, yaw_gain});
      s1_r   <= roll_reverse ? -roll_prod : roll_prod;
      s1_thr <= 20'(in_thr) * 20'(throttle_gain);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: x-frame mix, base term reciprocal multiply
  // ---------------------------------------------------------------------------
  logic signed [24:0] px, rx, yx;
  logic signed [24:0] s2_mix [M];
  logic [43:0]        s2_bprod;

  assign px = 25'(s1_p);
  assign rx = 25'(s1_r);
  assign yx = 25'(s1_y);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mix[0] <= -px + yx + rx;   // front-left
      s2_mix[1] <= -px - yx - rx;   // front-right
      s2_mix[2] <=  px + yx - rx;   // rear-left
      s2_mix[3] <=  px - yx + rx;   // rear-right
      s2_bprod  <= 44'(s1_thr) * 44'(qmm_pkg::RECIP_1000);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: sign and magnitude of each sum, base term shift
  // ---------------------------------------------------------------------------
  logic [23:0] s3_mag [M];
  logic [M-1:0] s3_neg;
  logic [10:0] s3_base;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < M; i++) begin
        s3_neg[i] <= s2_mix[i][24];
        s3_mag[i] <= s2_mix[i][24] ? 24'(-s2_mix[i]) : s2_mix[i][23:0];
      end
      s3_base <= s2_bprod[43:qmm_pkg::RECIP_SHIFT];
    end
  end

  // ---------------------------------------------------------------------------
  // divider: overflow check, then one quotient bit per stage
  // quotients of 2048 or more clamp anyway, so they saturate
  // ---------------------------------------------------------------------------
  logic [23:0]              dv_rem  [DSTG][M];
  logic [qmm_pkg::QBITS-1:0] dv_q   [DSTG][M];
  logic [M-1:0]             dv_neg  [DSTG];
  logic [M-1:0]             dv_sat  [DSTG];
  logic [10:0]              dv_base [DSTG];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < M; i++) begin
        dv_sat[0][i] <= {1'b0, s3_mag[i]} >= (gsum_x << qmm_pkg::QBITS);
        dv_rem[0][i] <= s3_mag[i];
        dv_q[0][i]   <= '0;
      end
      dv_neg[0]  <= s3_neg;
      dv_base[0] <= s3_base;
    end
  end

  for (genvar d = 1; d < DSTG; d++) begin : g_div
    localparam int K = qmm_pkg::QBITS - d;
    logic [24:0]               dk;
    logic [23:0]               rem_next [M];
    logic [qmm_pkg::QBITS-1:0] q_next   [M];

    assign dk = gsum_x << K;

    always_comb begin
      for (int i = 0; i < M; i++) begin
        rem_next[i] = dv_rem[d-1][i];
        q_next[i]   = dv_q[d-1][i];
        if ({1'b0, dv_rem[d-1][i]} >= dk) begin
          rem_next[i] = dv_rem[d-1][i] - dk[23:0];
          q_next[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < M; i++) begin
          dv_rem[d][i] <= rem_next[i];
          dv_q[d][i]   <= q_next[i];
        end
        dv_neg[d]  <= dv_neg[d-1];
        dv_sat[d]  <= dv_sat[d-1];
        dv_base[d] <= dv_base[d-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // clamp stage: signed attitude term plus base, limited to 0..1000
  // ---------------------------------------------------------------------------
  logic [qmm_pkg::SPEED_W-1:0] spd_next [M];
  logic [qmm_pkg::SPEED_W-1:0] s16_spd  [M];

  always_comb begin
    for (int i = 0; i < M; i++) begin
      logic [11:0]        qmag;
      logic signed [12:0] att;
      logic signed [12:0] sum;
      qmag = dv_sat[DSTG-1][i] ? 12'd2047 : {1'b0, dv_q[DSTG-1][i]};
      att  = dv_neg[DSTG-1][i] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      // zero gain sum leaves only the base term
      if (gsum == 14'd0) att = '0;
      sum = $signed({2'b00, dv_base[DSTG-1]}) + att;
      if (sum < 0) spd_next[i] = '0;
      else if (sum > $signed({3'b000, qmm_pkg::SPEED_FULL})) spd_next[i] = qmm_pkg::SPEED_FULL;
      else spd_next[i] = sum[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s16_spd <= spd_next;
    end
  end

  // ---------------------------------------------------------------------------
  // pwm map: speed*|span|, reciprocal multiply, then offset from pwm_min
  // ---------------------------------------------------------------------------
  logic [23:0]                 s17_prod [M];
  logic [qmm_pkg::SPEED_W-1:0] s17_spd  [M];
  logic [47:0]                 s18_prod [M];
  logic [qmm_pkg::SPEED_W-1:0] s18_spd  [M];
  logic [qmm_pkg::SPEED_W-1:0] out_spd  [M];
  logic [qmm_pkg::PWM_W-1:0]   out_pwm  [M];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < M; i++) begin
        s17_prod[i] <= 24'(s16_spd[i]) * 24'(span_abs);
        s17_spd[i]  <= s16_spd[i];
        s18_prod[i] <= 48'(s17_prod[i]) * 48'(qmm_pkg::RECIP_1000);
        s18_spd[i]  <= s17_spd[i];
        out_spd[i]  <= s18_spd[i];
        // the step always lies between the two limits, no wrap
        out_pwm[i]  <= span_neg
                       ? pwm_min - s18_prod[i][46:qmm_pkg::RECIP_SHIFT]
                       : pwm_min + s18_prod[i][46:qmm_pkg::RECIP_SHIFT];
      end
    end
  end

  assign m_axis_tdata = {out_pwm[3], out_pwm[2], out_pwm[1], out_pwm[0],
                         out_spd[3], out_spd[2], out_spd[1], out_spd[0]};

endmodule
